>>> sv/tcw_pkg.sv
// tcw_pkg: shared types, constants and codes for the text console writer
// no dependencies
`timescale 1ns / 1ps
package tcw_pkg;
   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;
   localparam logic [7:0] CODE_BACKSPACE  = 8'd127;
   localparam logic [7:0] CODE_CR         = 8'd13;
   localparam logic [7:0] CODE_LF         = 8'd10;
   localparam logic [7:0] CODE_SPACE      = 8'd32;
   localparam logic [7:0] CODE_PERIOD     = 8'd46;
   localparam logic [7:0] RESET_ATTRIBUTE = 8'd2;
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_PRINT, OP_NEWLINE, OP_BACKSPACE, OP_CLEAR, OP_READ, OP_NONE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  ch;
      logic [10:0] index;
      logic        in_range;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PRINT, ST_BACK, ST_READ_WAIT, ST_READ_DONE, ST_NEWLINE,
      ST_SCROLL_RD, ST_SCROLL_WR, ST_BLANK, ST_CLEAR, ST_OUT
   } state_type;
endpackage

>>> sv/text_console_writer.sv
// text_console_writer: top level, front classifier plus back executor
// depends on tcw_pkg, tcw_front, tcw_back
`timescale 1ns / 1ps
// Usage: request beats (req_kind, req_char_code, req_cell_index) enter on a
// valid/ready channel; every beat yields one response beat carrying the
// cursor position after the item and, for reads, the cell contents.
// csr_write/csr_data set the attribute byte used for printed and blanked cells.
// A scroll reads each cell of the lower rows and rewrites it one row up, then
// blanks the bottom row; a clear blanks every cell of the screen.
// The back takes the next beat in the cycle after the response beat leaves,
// so it works on one beat at a time.
// A two-entry queue lets the front take beats while the back is busy.
// Reset: after reset a clearing pass fills the screen with spaces in
// attribute 2; queued beats wait until it ends.
// If the receiver stalls, the response register holds and the back waits
// before taking the next beat; the queue then fills and req_ready falls.
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS = tcw_pkg::ROWS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [10:0] rsp_cursor_position,
   output logic [7:0]  rsp_cell_char,
   output logic [7:0]  rsp_cell_attribute,
   input  logic        csr_write,
   input  logic [7:0]  csr_data
);
   tcw_pkg::cmd_type cmd;
   logic cmd_valid, cmd_take;

   tcw_front #(.CELLS(COLUMNS * ROWS)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_char_code(req_char_code),
      .req_cell_index(req_cell_index), .cmd_valid(cmd_valid),
      .cmd_take(cmd_take), .cmd(cmd));

   tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_data(csr_data),
      .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_cursor_position(rsp_cursor_position), .rsp_cell_char(rsp_cell_char),
      .rsp_cell_attribute(rsp_cell_attribute));
endmodule

>>> sv/tcw_ram.sv
// tcw_ram: generic single-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> sv/tcw_front.sv
// tcw_front: accepts request beats, classifies them, two-entry queue to back
// depends on tcw_pkg
`timescale 1ns / 1ps
module tcw_front #(
   parameter int CELLS = 2000
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_kind,
   input  logic [7:0]       req_char_code,
   input  logic [10:0]      req_cell_index,
   output logic             cmd_valid,
   input  logic             cmd_take,
   output tcw_pkg::cmd_type cmd
);
   tcw_pkg::cmd_type q_ff [2];
   tcw_pkg::cmd_type q_in;
   logic [1:0] count_ff, count_in;
   logic rd_ff, wr_ff;
   logic push, pop;

   // classify one beat
   always_comb begin
      q_in.ch = req_char_code;
      q_in.index = req_cell_index;
      q_in.in_range = ({21'd0, req_cell_index} < 32'(CELLS));
      case (req_kind)
         tcw_pkg::KIND_WRITE: begin
            if (req_char_code == tcw_pkg::CODE_CR || req_char_code == tcw_pkg::CODE_LF)
               q_in.op = tcw_pkg::OP_NEWLINE;
            else if (req_char_code == tcw_pkg::CODE_BACKSPACE)
               q_in.op = tcw_pkg::OP_BACKSPACE;
            else begin
               q_in.op = tcw_pkg::OP_PRINT;
               if (req_char_code < tcw_pkg::CODE_SPACE || req_char_code[7])
                  q_in.ch = tcw_pkg::CODE_PERIOD;
            end
         end
         tcw_pkg::KIND_CLEAR: q_in.op = tcw_pkg::OP_CLEAR;
         tcw_pkg::KIND_READ:  q_in.op = tcw_pkg::OP_READ;
         default:             q_in.op = tcw_pkg::OP_NONE;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop = cmd_valid && cmd_take;
   assign cmd = q_ff[rd_ff];
   assign count_in = count_ff + {1'b0, push} - {1'b0, pop};

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= q_in;
   end
endmodule

>>> sv/tcw_back.sv
// tcw_back: executes classified commands on the screen ram, drives response
// depends on tcw_pkg and tcw_ram
`timescale 1ns / 1ps
module tcw_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS = 25,
   localparam int CELLS = COLUMNS * ROWS,
   localparam int AW = $clog2(CELLS),
   localparam int CW = $clog2(COLUMNS),
   localparam int RW = $clog2(ROWS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write,
   input  logic [7:0]       csr_data,
   input  logic             cmd_valid,
   output logic             cmd_take,
   input  tcw_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [10:0]      rsp_cursor_position,
   output logic [7:0]       rsp_cell_char,
   output logic [7:0]       rsp_cell_attribute
);
   tcw_pkg::state_type state_ff, state_in;
   logic [7:0] attr_ff;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [AW-1:0] base_ff, base_in;    // row_ff * COLUMNS
   logic [AW-1:0] addr_ff, addr_in;    // sweep pointer
   tcw_pkg::cmd_type cmd_ff;
   logic [10:0] pos_ff, pos_in;
   logic [15:0] data_ff, data_in;
   logic rv_ff, rv_in;
   logic we;
   logic [AW-1:0] wa, ra;
   logic [15:0] wd, rd;
   logic last_col, last_row;

   tcw_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd));

   assign last_col = (col_ff == CW'(COLUMNS - 1));
   assign last_row = (row_ff == RW'(ROWS - 1));

   // sequencer for one command
   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      col_in = col_ff;
      base_in = base_ff;
      addr_in = addr_ff;
      pos_in = pos_ff;
      data_in = data_ff;
      rv_in = rv_ff;
      cmd_take = 1'b0;
      we = 1'b0;
      wa = base_ff + AW'(col_ff);
      wd = {attr_ff, tcw_pkg::CODE_SPACE};
      ra = AW'(cmd_ff.index);
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (cmd_valid && !rv_ff) begin
               cmd_take = 1'b1;
               data_in = 16'd0;
               case (cmd.op)
                  tcw_pkg::OP_PRINT:     state_in = tcw_pkg::ST_PRINT;
                  tcw_pkg::OP_NEWLINE:   state_in = tcw_pkg::ST_NEWLINE;
                  tcw_pkg::OP_BACKSPACE: state_in = tcw_pkg::ST_BACK;
                  tcw_pkg::OP_CLEAR: begin
                     addr_in = '0;
                     state_in = tcw_pkg::ST_CLEAR;
                  end
                  tcw_pkg::OP_READ:
                     state_in = cmd.in_range ? tcw_pkg::ST_READ_WAIT : tcw_pkg::ST_OUT;
                  default: state_in = tcw_pkg::ST_OUT;
               endcase
            end
         end
         tcw_pkg::ST_PRINT: begin
            we = 1'b1;
            wd = {attr_ff, cmd_ff.ch};
            if (last_col) state_in = tcw_pkg::ST_NEWLINE;
            else begin
               col_in = col_ff + CW'(1);
               state_in = tcw_pkg::ST_OUT;
            end
         end
         tcw_pkg::ST_BACK: begin
            // step back within the line unless at column zero, then blank the cell
            if (col_ff != '0) begin
               col_in = col_ff - CW'(1);
               state_in = tcw_pkg::ST_BLANK;
               addr_in = base_ff + AW'(col_ff) - AW'(1);
            end else begin
               we = 1'b1;
               state_in = tcw_pkg::ST_OUT;
            end
         end
         tcw_pkg::ST_BLANK: begin
            we = 1'b1;
            wa = addr_ff;
            if (addr_ff == AW'(CELLS - 1))
               state_in = tcw_pkg::ST_OUT;
            else if (cmd_ff.op == tcw_pkg::OP_BACKSPACE)
               state_in = tcw_pkg::ST_OUT;
            else
               addr_in = addr_ff + AW'(1);
         end
         tcw_pkg::ST_READ_WAIT: state_in = tcw_pkg::ST_READ_DONE;
         tcw_pkg::ST_READ_DONE: begin
            data_in = rd;
            state_in = tcw_pkg::ST_OUT;
         end
         tcw_pkg::ST_NEWLINE: begin
            col_in = '0;
            if (!last_row) begin
               row_in = row_ff + RW'(1);
               base_in = base_ff + AW'(COLUMNS);
               state_in = tcw_pkg::ST_OUT;
            end else begin
               addr_in = '0;
               state_in = tcw_pkg::ST_SCROLL_RD;
            end
         end
         tcw_pkg::ST_SCROLL_RD: begin
            // read cell one row below the sweep pointer
            ra = addr_ff + AW'(COLUMNS);
            state_in = tcw_pkg::ST_SCROLL_WR;
         end
         tcw_pkg::ST_SCROLL_WR: begin
            we = 1'b1;
            wa = addr_ff;
            wd = rd;
            ra = addr_ff + AW'(COLUMNS + 1);
            addr_in = addr_ff + AW'(1);
            if (addr_ff == AW'(CELLS - COLUMNS - 1)) state_in = tcw_pkg::ST_BLANK;
            else state_in = tcw_pkg::ST_SCROLL_RD;
         end
         tcw_pkg::ST_CLEAR: begin
            // the clearing pass after reset returns to idle without a response
            we = 1'b1;
            wa = addr_ff;
            addr_in = addr_ff + AW'(1);
            if (addr_ff == AW'(CELLS - 1)) begin
               row_in = '0;
               col_in = '0;
               base_in = '0;
               state_in = (cmd_ff.op == tcw_pkg::OP_CLEAR) ? tcw_pkg::ST_OUT
                                                           : tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_OUT: begin
            if (!rv_ff) begin
               pos_in = 11'(base_ff) + 11'(col_ff);
               rv_in = 1'b1;
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         default: state_in = tcw_pkg::ST_IDLE;
      endcase
   end

   // control state; reset runs a clearing pass over the screen
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcw_pkg::ST_CLEAR;
         addr_ff <= '0;
         row_ff <= '0;
         col_ff <= '0;
         base_ff <= '0;
         rv_ff <= 1'b0;
         cmd_ff.op <= tcw_pkg::OP_NONE;
         attr_ff <= tcw_pkg::RESET_ATTRIBUTE;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         row_ff <= row_in;
         col_ff <= col_in;
         base_ff <= base_in;
         rv_ff <= rv_in;
         if (cmd_take) cmd_ff <= cmd;
         if (csr_write) attr_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      data_ff <= data_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_cursor_position = pos_ff;
   assign rsp_cell_char = data_ff[7:0];
   assign rsp_cell_attribute = data_ff[15:8];
endmodule

>>> sv/tcw_checker.sv
// tcw_checker: port-level assertions for the text console writer
// depends on text_console_writer ports; bound to the top level
`timescale 1ns / 1ps
module tcw_checker #(
   parameter int CELLS = tcw_pkg::COLUMNS_DEFAULT * tcw_pkg::ROWS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [10:0] rsp_cursor_position,
   input logic [7:0]  rsp_cell_char
);
   // stalled response beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_position)
         && $stable(rsp_cell_char))
      else $error("response changed while stalled");
   // no response right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response during reset");
   // cursor stays on the screen
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_cursor_position) < 32'(CELLS))
      else $error("cursor out of range");
   // a waiting request beat stays offered
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("request withdrawn before accept");
endmodule

bind text_console_writer tcw_checker #(.CELLS(COLUMNS * ROWS)) u_tcw_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_cursor_position(rsp_cursor_position), .rsp_cell_char(rsp_cell_char));

>>> verif/text_console_checker.sv
// text_console_checker: watches the request, response and csr ports of the console
// writer, keeps its own screen and cursor, and compares every response beat
// depends on tcw_pkg
`timescale 1ns / 1ps
module text_console_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_index,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [10:0] rsp_cursor_position,
   input  logic [7:0]  rsp_cell_char,
   input  logic [7:0]  rsp_cell_attribute,
   input  logic        csr_write,
   input  logic [7:0]  csr_data,
   output int          fail_count,
   output int          pending_count,
   output int          checked_count,
   output int          scroll_count
);
   localparam int CELLS = ROWS * COLUMNS;

   typedef struct packed {
      logic [10:0] cursor;
      logic [7:0]  ch;
      logic [7:0]  attr;
   } console_rsp_type;

   logic [15:0]     screen [CELLS];
   int              cur_row;
   int              cur_col;
   logic [7:0]      attribute;
   console_rsp_type expected_rsp [$];

   assign pending_count = expected_rsp.size();

   function automatic logic [15:0] blank_cell();
      return {attribute, tcw_pkg::CODE_SPACE};
   endfunction

   // line feed: home column, step down or scroll the whole screen up one row
   function void advance_line();
      cur_col = 0;
      if (cur_row < ROWS - 1) begin
         cur_row++;
      end else begin
         for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
         for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = blank_cell();
         scroll_count++;
      end
   endfunction

   function void place_char(logic [7:0] ch);
      screen[cur_row * COLUMNS + cur_col] = {attribute, ch};
      cur_col++;
      if (cur_col >= COLUMNS) advance_line();
   endfunction

   function void blank_screen();
      for (int i = 0; i < CELLS; i++) screen[i] = blank_cell();
      cur_row = 0;
      cur_col = 0;
   endfunction

   // apply one request beat to the screen and return the response it yields
   function console_rsp_type apply_request(logic [1:0] kind, logic [7:0] code,
                                           logic [10:0] idx);
      console_rsp_type r;
      int pos;
      r = '0;
      case (kind)
         tcw_pkg::KIND_WRITE: begin
            if (code == tcw_pkg::CODE_CR || code == tcw_pkg::CODE_LF) begin
               advance_line();
            end else if (code == tcw_pkg::CODE_BACKSPACE) begin
               if (cur_col > 0) cur_col--;
               screen[cur_row * COLUMNS + cur_col] = blank_cell();
            end else if (code >= tcw_pkg::CODE_SPACE && code < tcw_pkg::CODE_BACKSPACE) begin
               place_char(code);
            end else begin
               place_char(tcw_pkg::CODE_PERIOD);
            end
         end
         tcw_pkg::KIND_CLEAR: blank_screen();
         tcw_pkg::KIND_READ: begin
            if (int'(idx) < CELLS) begin
               r.ch   = screen[idx][7:0];
               r.attr = screen[idx][15:8];
            end
         end
         default: ;
      endcase
      pos = cur_row * COLUMNS + cur_col;
      r.cursor = pos[10:0];
      return r;
   endfunction

   always @(posedge clock) begin
      console_rsp_type exp_r;
      if (reset) begin
         attribute = tcw_pkg::RESET_ATTRIBUTE;
         blank_screen();
         expected_rsp.delete();
         fail_count    = 0;
         checked_count = 0;
         scroll_count  = 0;
      end else begin
         if (csr_write) attribute = csr_data;
         // request beat: predict
         if (req_valid && req_ready)
            expected_rsp.push_back(apply_request(req_kind, req_char_code, req_cell_index));
         // response beat: compare with oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response beat with no request outstanding");
               fail_count++;
            end else begin
               exp_r = expected_rsp.pop_front();
               checked_count++;
               if (rsp_cursor_position !== exp_r.cursor) begin
                  $error("cursor_position expected %0d actual %0d", exp_r.cursor,
                         rsp_cursor_position);
                  fail_count++;
               end
               if (rsp_cell_char !== exp_r.ch) begin
                  $error("cell_char expected %0h actual %0h", exp_r.ch, rsp_cell_char);
                  fail_count++;
               end
               if (rsp_cell_attribute !== exp_r.attr) begin
                  $error("cell_attribute expected %0h actual %0h", exp_r.attr,
                         rsp_cell_attribute);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

>>> verif/text_console_writer_tb.sv
// text_console_writer_tb: clock, reset, request stimulus, csr writes and verdict
// depends on tcw_pkg, text_console_writer, text_console_checker
`timescale 1ns / 1ps
module text_console_writer_tb;
   // worst case: every beat scrolls the whole screen under stalls
   localparam int CYCLE_LIMIT = 20000000;
   localparam int DRAIN_CYCLES = 60;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_kind = tcw_pkg::KIND_WRITE;
   logic [7:0]  req_char_code = '0;
   logic [10:0] req_cell_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [10:0] rsp_cursor_position;
   logic [7:0]  rsp_cell_char;
   logic [7:0]  rsp_cell_attribute;
   logic        csr_write = 1'b0;
   logic [7:0]  csr_data = '0;

   int  fail_count, pending_count, checked_count, scroll_count;
   int  cycle_count = 0;
   int  idle_pct = 0;
   int  stall_pct = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_console_writer dut (.*);

   text_console_checker #(
      .COLUMNS(tcw_pkg::COLUMNS_DEFAULT), .ROWS(tcw_pkg::ROWS_DEFAULT)
   ) u_checker (.*);

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // one request beat, holding valid until accepted
   task automatic send_beat(logic [1:0] kind, logic [7:0] code, logic [10:0] idx);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_char_code  <= code;
      req_cell_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // idle the request side and wait until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_attribute(logic [7:0] value);
      csr_write <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // random mix: mostly text with line breaks, some reads, rare clears
   task automatic random_beats(int count);
      logic [1:0]  kind;
      logic [7:0]  code;
      logic [10:0] idx;
      int          pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         kind = (pick < 78) ? tcw_pkg::KIND_WRITE : (pick < 80) ? tcw_pkg::KIND_CLEAR :
                (pick < 98) ? tcw_pkg::KIND_READ : KIND_UNUSED;
         pick = $urandom_range(99);
         if (pick < 70) code = 8'($urandom_range(126, 32));
         else if (pick < 76) code = tcw_pkg::CODE_LF;
         else if (pick < 79) code = tcw_pkg::CODE_CR;
         else if (pick < 85) code = tcw_pkg::CODE_BACKSPACE;
         else code = 8'($urandom_range(255));
         idx = ($urandom_range(9) == 0) ? 11'($urandom_range(2047))
                                        : 11'($urandom_range(1999));
         send_beat(kind, code, idx);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: reset contents, backspace at column zero, code classes
      send_beat(tcw_pkg::KIND_READ, 8'd0, 11'd1999);
      send_beat(tcw_pkg::KIND_WRITE, tcw_pkg::CODE_BACKSPACE, 11'd0);
      send_beat(tcw_pkg::KIND_WRITE, 8'd0, 11'd0);
      send_beat(tcw_pkg::KIND_WRITE, 8'd255, 11'd0);
      send_beat(tcw_pkg::KIND_WRITE, 8'd31, 11'd0);
      send_beat(tcw_pkg::KIND_WRITE, 8'd128, 11'd0);
      send_beat(tcw_pkg::KIND_WRITE, tcw_pkg::CODE_SPACE, 11'd0);
      send_beat(tcw_pkg::KIND_WRITE, 8'd126, 11'd0);
      send_beat(tcw_pkg::KIND_WRITE, tcw_pkg::CODE_CR, 11'd0);
      send_beat(tcw_pkg::KIND_WRITE, 8'h41, 11'd0);
      send_beat(tcw_pkg::KIND_WRITE, tcw_pkg::CODE_LF, 11'd0);
      send_beat(tcw_pkg::KIND_WRITE, tcw_pkg::CODE_BACKSPACE, 11'd0);
      send_beat(tcw_pkg::KIND_READ, 8'd0, 11'd0);
      send_beat(tcw_pkg::KIND_READ, 8'd0, 11'd3);
      send_beat(tcw_pkg::KIND_READ, 8'd0, 11'd80);
      send_beat(tcw_pkg::KIND_READ, 8'd0, 11'd2000);
      send_beat(tcw_pkg::KIND_READ, 8'hFF, 11'd2047);
      send_beat(KIND_UNUSED, 8'hFF, 11'h7FF);
      send_beat(tcw_pkg::KIND_CLEAR, 8'd0, 11'd0);
      send_beat(tcw_pkg::KIND_READ, 8'd0, 11'd1);
      drain();

      // four phases of request gaps and back-pressure, each with its own attribute
      write_attribute(8'hFF);
      random_beats(375);
      drain();
      write_attribute(8'h00);
      idle_pct = 74;
      random_beats(375);
      drain();
      write_attribute(8'($urandom_range(255)));
      idle_pct = 0;
      stall_pct = 74;
      random_beats(375);
      drain();
      write_attribute(8'h5A);
      idle_pct = 22;
      stall_pct = 22;
      random_beats(375);
      drain();

      $display("checked %0d response beats over %0d cycles, %0d screen scrolls",
               checked_count, cycle_count, scroll_count);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("FAIL");
      end
      $finish;
   end
endmodule
